// File: rtl/ssp_pkg.sv
`timescale 1ns / 1ps
package ssp_pkg;

  // default number of fraction bits of the fixed point fields
  localparam int FRACTION_BITS_DEF = 16;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // quotient bits kept by the two divider rows
  localparam int DEPTH_QW  = 32;
  localparam int SCREEN_QW = 16;

  typedef enum logic [2:0] {
    REG_WINDOW_WIDTH       = 3'd0,
    REG_WINDOW_HEIGHT      = 3'd1,
    REG_VERTICAL_MOVE      = 3'd2,
    REG_VERTICAL_DIVISOR   = 3'd3,
    REG_HORIZONTAL_DIVISOR = 3'd4
  } ssp_reg_e;

  typedef struct packed {
    logic [12:0] window_width;
    logic [12:0] window_height;
    logic [12:0] vertical_move;
    logic [4:0]  vertical_divisor;
    logic [4:0]  horizontal_divisor;
  } ssp_cfg_t;

  localparam ssp_cfg_t CFG_RESET = '{
    window_width:       13'd640,
    window_height:      13'd480,
    vertical_move:      13'd0,
    vertical_divisor:   5'd1,
    horizontal_divisor: 5'd1
  };

endpackage

// File: rtl/ssp_if.sv
`timescale 1ns / 1ps
interface ssp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sprite_x;
  logic signed [31:0] sprite_y;
  logic signed [31:0] camera_x;
  logic signed [31:0] camera_y;
  logic signed [31:0] direction_x;
  logic signed [31:0] direction_y;
  logic signed [31:0] plane_x;
  logic signed [31:0] plane_y;

  modport source (
    output valid, sprite_x, sprite_y, camera_x, camera_y,
           direction_x, direction_y, plane_x, plane_y,
    input  ready
  );
  modport sink (
    input  valid, sprite_x, sprite_y, camera_x, camera_y,
           direction_x, direction_y, plane_x, plane_y,
    output ready
  );
endinterface

interface ssp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_column;
  logic signed [31:0] depth;
  logic signed [15:0] vertical_shift;
  logic [14:0]        sprite_height;
  logic [14:0]        sprite_width;
  logic [14:0]        row_start;
  logic signed [15:0] row_end;
  logic [14:0]        column_start;
  logic signed [15:0] column_end;
  logic               error_flag;

  modport source (
    output valid, screen_column, depth, vertical_shift, sprite_height, sprite_width,
           row_start, row_end, column_start, column_end, error_flag,
    input  ready
  );
  modport sink (
    input  valid, screen_column, depth, vertical_shift, sprite_height, sprite_width,
           row_start, row_end, column_start, column_end, error_flag,
    output ready
  );
endinterface

// File: rtl/ssp_cfg.sv
`timescale 1ns / 1ps
module ssp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssp_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssp_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output ssp_pkg::ssp_cfg_t            cfg_o
);
  import ssp_pkg::*;

  ssp_cfg_t cfg_q, cfg_d;
  ssp_reg_e reg_idx;

  assign reg_idx = ssp_reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW_WIDTH:       cfg_d.window_width       = pwdata[12:0];
        REG_WINDOW_HEIGHT:      cfg_d.window_height      = pwdata[12:0];
        REG_VERTICAL_MOVE:      cfg_d.vertical_move      = pwdata[12:0];
        REG_VERTICAL_DIVISOR:   cfg_d.vertical_divisor   = pwdata[4:0];
        REG_HORIZONTAL_DIVISOR: cfg_d.horizontal_divisor = pwdata[4:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_WIDTH:       prdata = PDATA_W'(cfg_q.window_width);
      REG_WINDOW_HEIGHT:      prdata = PDATA_W'(cfg_q.window_height);
      REG_VERTICAL_MOVE:      prdata = PDATA_W'(cfg_q.vertical_move);
      REG_VERTICAL_DIVISOR:   prdata = PDATA_W'(cfg_q.vertical_divisor);
      REG_HORIZONTAL_DIVISOR: prdata = PDATA_W'(cfg_q.horizontal_divisor);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/ssp_div.sv
`timescale 1ns / 1ps
module ssp_div #(
  parameter int NW = 81,
  parameter int DW = 65,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic          neg_o,
  output logic          ovf_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  // magnitude stage
  logic [NW-1:0] n_abs;
  logic [DW-1:0] d_abs;
  logic          abs_v_q;
  logic [CW-1:0] na_q;
  logic [DW-1:0] da_q;
  logic          abs_neg_q;
  logic [SW-1:0] abs_side_q;

  // range check then one quotient bit per stage
  logic          v_q    [QW+1];
  logic [CW-1:0] r_q    [QW+1];
  logic [DW-1:0] d_q    [QW+1];
  logic [QW-1:0] q_q    [QW+1];
  logic          neg_q  [QW+1];
  logic          ovf_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  assign n_abs = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign d_abs = den_i[DW-1] ? (~den_i + 1'b1) : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_v_q <= 1'b0;
      v_q[0]  <= 1'b0;
    end else if (en_i) begin
      abs_v_q <= valid_i;
      v_q[0]  <= abs_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q       <= CW'(n_abs);
      da_q       <= d_abs;
      abs_neg_q  <= num_i[NW-1] ^ den_i[DW-1];
      abs_side_q <= side_i;
      // quotient needs more than QW bits
      ovf_q[0]   <= na_q >= (CW'(da_q) << QW);
      r_q[0]     <= na_q;
      d_q[0]     <= da_q;
      q_q[0]     <= '0;
      neg_q[0]   <= abs_neg_q;
      side_q[0]  <= abs_side_q;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int BIT = QW - 1 - s;
    logic [CW-1:0] trial;
    logic          ge;
    logic [QW-1:0] q_next;

    always_comb begin
      trial       = CW'(d_q[s]) << BIT;
      ge          = r_q[s] >= trial;
      q_next      = q_q[s];
      q_next[BIT] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]    <= ge ? (r_q[s] - trial) : r_q[s];
        d_q[s+1]    <= d_q[s];
        q_q[s+1]    <= q_next;
        neg_q[s+1]  <= neg_q[s];
        ovf_q[s+1]  <= ovf_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign neg_o   = neg_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign quo_o   = q_q[QW];
  assign side_o  = side_q[QW];

endmodule

// File: rtl/sprite_screen_projection_top.sv
`timescale 1ns / 1ps
// channel   | dir | handshake      | payload
// ----------+-----+----------------+----------------------------------------------
// in_i      | in  | valid / ready  | sprite, camera, direction, plane (Q16.16)
// out_o     | out | valid / ready  | column, depth, shift, size, row/col span, err
// apb       | in  | psel / penable | window size, vertical move, divisors
//
// one sprite request per cycle while no result waits unread
// most of the pipeline is two rows of bit-per-stage dividers (34 and 18 stages)
// the whole pipeline advances together; it holds while a result waits unread
// reset clears valid bits and restores the register defaults
// register writes are taken at any time and are meant for an idle pipeline
module sprite_screen_projection_top #(
  parameter int FRACTION_BITS = ssp_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ssp_in_if.sink                      in_i,
  ssp_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssp_pkg::PADDR_W-1:0] paddr,
  input  logic [ssp_pkg::PDATA_W-1:0] pwdata,
  output logic [ssp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ssp_pkg::*;

  // numerator and denominator widths of the divider rows
  localparam int NXW = 65 + FRACTION_BITS;
  localparam int VNW = 13 + FRACTION_BITS;
  localparam int HNW = 14 + FRACTION_BITS;
  localparam int CNW = 46;
  localparam int HDW = 38;

  ssp_cfg_t cfg;
  logic     en;

  // stage 1: position differences
  logic        v1_q;
  logic [32:0] dx1_q, dy1_q;
  logic [31:0] drx1_q, dry1_q, plx1_q, ply1_q;
  // stage 2: products, wrapped to 64 bits
  logic               v2_q;
  logic signed [63:0] pd1_d, pd2_d;
  logic signed [64:0] px1_full, px2_full, py1_full, py2_full;
  logic [63:0]        pd1_q, pd2_q, px1_q, px2_q, py1_q, py2_q;
  // stage 3: determinant and numerators
  logic        v3_q;
  logic [64:0] det3_q, numx3_q, numy3_q;
  logic        dz3_q;
  // camera-space divider row
  logic        va, nega, ovfa, negb, ovfb, dza;
  logic [31:0] quoa, quob;
  // stage 5: saturated lateral and depth
  logic        v5_q, err5_q;
  logic [31:0] tx5_q, ty5_q;
  // stage 6
  logic        v6_q, err6_q;
  logic [32:0] sum6_q;
  logic [31:0] aty6_q, ty6_q;
  // stage 7: screen-space operands
  logic               v7_q, err7_q;
  logic signed [45:0] cprod;
  logic [36:0]        hprod, wprod;
  logic [4:0]         vdiv_eff, hdiv_eff;
  logic [CNW-1:0]     cnum7_q;
  logic [VNW-1:0]     vnum7_q;
  logic [HNW-1:0]     hnum7_q;
  logic [HDW-1:0]     hden7_q, wden7_q;
  logic [31:0]        ty7_q;
  // screen divider row
  logic        vc, negc, ovfc, negv, ovfv, ovfh, ovfw;
  logic [15:0] quoc, quov, quoh, quow;
  logic [32:0] sidec;
  // stage 8: saturated screen values
  logic        v8_q, err8_q;
  logic [15:0] col8_q, vsh8_q;
  logic [14:0] hgt8_q, wid8_q;
  logic [31:0] ty8_q;
  // stage 9: span and output register
  logic signed [17:0] rs_raw, re_raw, cs_raw, ce_raw;
  logic [14:0]        rs_d, cs_d;
  logic [15:0]        re_d, ce_d;
  logic               v9_q;
  logic [15:0]        col9_q, vsh9_q, re9_q, ce9_q;
  logic [31:0]        ty9_q;
  logic [14:0]        hgt9_q, wid9_q, rs9_q, cs9_q;
  logic               err9_q;

  function automatic logic [31:0] sat_depth(logic neg, logic ovf, logic [31:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (ovf || mag > 32'h8000_0000) ? 32'h8000_0000 : (~mag + 32'd1);
    end else begin
      r = (ovf || mag[31]) ? 32'h7fff_ffff : mag;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_screen(logic neg, logic ovf, logic [15:0] mag);
    logic [15:0] r;
    if (neg) begin
      r = (ovf || mag[15]) ? 16'h8000 : (~mag + 16'd1);
    end else begin
      r = (ovf || mag >= 16'h7fff) ? 16'h7fff : mag;
    end
    return r;
  endfunction

  function automatic logic [14:0] sat_size(logic ovf, logic [15:0] mag);
    return (ovf || mag >= 16'h7fff) ? 15'h7fff : mag[14:0];
  endfunction

  ssp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // global advance: the output register is free or being read
  assign en       = !v9_q || out_o.ready;
  assign in_i.ready = en;

  // valid chain outside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v5_q <= va;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= vc;
      v9_q <= v8_q;
    end
  end

  // products need the wrapped 64 bit value
  assign pd1_d    = $signed(plx1_q) * $signed(dry1_q);
  assign pd2_d    = $signed(drx1_q) * $signed(ply1_q);
  assign px1_full = $signed(dry1_q) * $signed(dx1_q);
  assign px2_full = $signed(drx1_q) * $signed(dy1_q);
  assign py1_full = $signed(plx1_q) * $signed(dy1_q);
  assign py2_full = $signed(ply1_q) * $signed(dx1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q   <= {in_i.sprite_x[31], in_i.sprite_x} - {in_i.camera_x[31], in_i.camera_x};
      dy1_q   <= {in_i.sprite_y[31], in_i.sprite_y} - {in_i.camera_y[31], in_i.camera_y};
      drx1_q  <= in_i.direction_x;
      dry1_q  <= in_i.direction_y;
      plx1_q  <= in_i.plane_x;
      ply1_q  <= in_i.plane_y;

      pd1_q   <= pd1_d;
      pd2_q   <= pd2_d;
      px1_q   <= px1_full[63:0];
      px2_q   <= px2_full[63:0];
      py1_q   <= py1_full[63:0];
      py2_q   <= py2_full[63:0];

      det3_q  <= {pd1_q[63], pd1_q} - {pd2_q[63], pd2_q};
      numx3_q <= {px1_q[63], px1_q} - {px2_q[63], px2_q};
      numy3_q <= {py1_q[63], py1_q} - {py2_q[63], py2_q};
      // determinant is zero exactly when both products agree
      dz3_q   <= pd1_q == pd2_q;
    end
  end

  // lateral offset and depth, numerators scaled by the fraction
  ssp_div #(.NW(NXW), .DW(65), .QW(DEPTH_QW), .SW(1)) u_div_tx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   ({numx3_q, {FRACTION_BITS{1'b0}}}),
    .den_i   (det3_q),
    .side_i  (dz3_q),
    .valid_o (va),
    .neg_o   (nega),
    .ovf_o   (ovfa),
    .quo_o   (quoa),
    .side_o  (dza)
  );

  ssp_div #(.NW(NXW), .DW(65), .QW(DEPTH_QW), .SW(1)) u_div_ty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   ({numy3_q, {FRACTION_BITS{1'b0}}}),
    .den_i   (det3_q),
    .side_i  (1'b0),
    .valid_o (),
    .neg_o   (negb),
    .ovf_o   (ovfb),
    .quo_o   (quob),
    .side_o  ()
  );

  // a zero divisor register acts as one
  assign vdiv_eff = (cfg.vertical_divisor == 5'd0) ? 5'd1 : cfg.vertical_divisor;
  assign hdiv_eff = (cfg.horizontal_divisor == 5'd0) ? 5'd1 : cfg.horizontal_divisor;
  assign cprod    = $signed({1'b0, cfg.window_width[12:1]}) * $signed(sum6_q);
  assign hprod    = aty6_q * vdiv_eff;
  assign wprod    = aty6_q * hdiv_eff;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx5_q   <= sat_depth(nega, ovfa, quoa);
      ty5_q   <= sat_depth(negb, ovfb, quob);
      err5_q  <= dza;

      // zero depth is an error just like a zero determinant
      err6_q  <= err5_q || (ty5_q == 32'd0);
      sum6_q  <= {tx5_q[31], tx5_q} + {ty5_q[31], ty5_q};
      aty6_q  <= ty5_q[31] ? (~ty5_q + 32'd1) : ty5_q;
      ty6_q   <= ty5_q;

      cnum7_q <= cprod;
      vnum7_q <= {cfg.vertical_move, {FRACTION_BITS{1'b0}}};
      hnum7_q <= {1'b0, cfg.window_height, {FRACTION_BITS{1'b0}}};
      hden7_q <= {1'b0, hprod};
      wden7_q <= {1'b0, wprod};
      ty7_q   <= ty6_q;
      err7_q  <= err6_q;
    end
  end

  // centre column, carries depth and error alongside
  ssp_div #(.NW(CNW), .DW(32), .QW(SCREEN_QW), .SW(33)) u_div_col (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (cnum7_q),
    .den_i   (ty7_q),
    .side_i  ({err7_q, ty7_q}),
    .valid_o (vc),
    .neg_o   (negc),
    .ovf_o   (ovfc),
    .quo_o   (quoc),
    .side_o  (sidec)
  );

  ssp_div #(.NW(VNW), .DW(32), .QW(SCREEN_QW), .SW(1)) u_div_vsh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (vnum7_q),
    .den_i   (ty7_q),
    .side_i  (1'b0),
    .valid_o (),
    .neg_o   (negv),
    .ovf_o   (ovfv),
    .quo_o   (quov),
    .side_o  ()
  );

  ssp_div #(.NW(HNW), .DW(HDW), .QW(SCREEN_QW), .SW(1)) u_div_hgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (hnum7_q),
    .den_i   (hden7_q),
    .side_i  (1'b0),
    .valid_o (),
    .neg_o   (),
    .ovf_o   (ovfh),
    .quo_o   (quoh),
    .side_o  ()
  );

  // width uses the window height too
  ssp_div #(.NW(HNW), .DW(HDW), .QW(SCREEN_QW), .SW(1)) u_div_wid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (hnum7_q),
    .den_i   (wden7_q),
    .side_i  (1'b0),
    .valid_o (),
    .neg_o   (),
    .ovf_o   (ovfw),
    .quo_o   (quow),
    .side_o  ()
  );

  // draw span, halvings round down
  always_comb begin
    rs_raw = $signed({6'b0, cfg.window_height[12:1]}) + $signed({{2{vsh8_q[15]}}, vsh8_q})
           - $signed({4'b0, hgt8_q[14:1]});
    re_raw = $signed({6'b0, cfg.window_height[12:1]}) + $signed({{2{vsh8_q[15]}}, vsh8_q})
           + $signed({4'b0, hgt8_q[14:1]});
    cs_raw = $signed({{2{col8_q[15]}}, col8_q}) - $signed({4'b0, wid8_q[14:1]});
    ce_raw = $signed({{2{col8_q[15]}}, col8_q}) + $signed({4'b0, wid8_q[14:1]});

    if (rs_raw[17]) begin
      rs_d = 15'd0;
    end else if (rs_raw > $signed(18'd32767)) begin
      rs_d = 15'h7fff;
    end else begin
      rs_d = rs_raw[14:0];
    end

    if (cs_raw[17]) begin
      cs_d = 15'd0;
    end else if (cs_raw > $signed(18'd32767)) begin
      cs_d = 15'h7fff;
    end else begin
      cs_d = cs_raw[14:0];
    end

    // an end past the window clamps to its size minus one, which is minus one for an empty window
    if (re_raw >= $signed({5'b0, cfg.window_height})) begin
      re_d = {3'b0, cfg.window_height} - 16'd1;
    end else begin
      re_d = re_raw[15:0];
    end

    if (ce_raw >= $signed({5'b0, cfg.window_width})) begin
      ce_d = {3'b0, cfg.window_width} - 16'd1;
    end else begin
      ce_d = ce_raw[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col8_q <= sat_screen(negc, ovfc, quoc);
      vsh8_q <= sat_screen(negv, ovfv, quov);
      hgt8_q <= sat_size(ovfh, quoh);
      wid8_q <= sat_size(ovfw, quow);
      ty8_q  <= sidec[31:0];
      err8_q <= sidec[32];

      // an error result carries only the flag
      err9_q <= err8_q;
      col9_q <= err8_q ? 16'd0 : col8_q;
      ty9_q  <= err8_q ? 32'd0 : ty8_q;
      vsh9_q <= err8_q ? 16'd0 : vsh8_q;
      hgt9_q <= err8_q ? 15'd0 : hgt8_q;
      wid9_q <= err8_q ? 15'd0 : wid8_q;
      rs9_q  <= err8_q ? 15'd0 : rs_d;
      re9_q  <= err8_q ? 16'd0 : re_d;
      cs9_q  <= err8_q ? 15'd0 : cs_d;
      ce9_q  <= err8_q ? 16'd0 : ce_d;
    end
  end

  assign out_o.valid          = v9_q;
  assign out_o.screen_column  = col9_q;
  assign out_o.depth          = ty9_q;
  assign out_o.vertical_shift = vsh9_q;
  assign out_o.sprite_height  = hgt9_q;
  assign out_o.sprite_width   = wid9_q;
  assign out_o.row_start      = rs9_q;
  assign out_o.row_end        = re9_q;
  assign out_o.column_start   = cs9_q;
  assign out_o.column_end     = ce9_q;
  assign out_o.error_flag     = err9_q;

endmodule
